@@ rtl/rtts_pkg.sv @@
// Shared codes, field widths and control/status bundles for the tick scheduler.
// No dependencies; every other file imports this package.
package rtts_pkg;

  localparam logic POL_EDF = 1'b0;
  localparam logic POL_RMS = 1'b1;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic REG_POLICY     = 1'b0;
  localparam logic REG_TASK_COUNT = 1'b1;

  localparam int IN_INDEX_W   = 3;
  localparam int IN_TIME_W    = 12;
  localparam int OUT_TASK_W   = 3;
  localparam int JOB_W        = 16;
  localparam int TASK_COUNT_W = 4;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  typedef struct packed {
    logic load;        // write one table entry from the input transfer
    logic tick;        // start a tick: arm selection, rewind the walk
    logic walk_start;  // rewind the table walk
    logic scan;        // walk compares keys
    logic cdn;         // walk runs the chosen task and counts periods down
    logic res_load;    // move the tick result into the output register
  } rtts_cmd_t;

  typedef struct packed {
    logic walk_done;   // walk finished and read pipeline drained
    logic keep_hit;    // current task may be kept under RMS
    logic out_full;    // output register holds a result not taken this cycle
  } rtts_sts_t;

endpackage

@@ rtl/rtts_regs.sv @@
// Configuration registers (policy, task count) behind the APB-style port.
// Depends on rtts_pkg for register codes and widths.
module rtts_regs import rtts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready,
  output logic                    policy,
  output logic [TASK_COUNT_W-1:0] task_count
);

  logic                    policy_r;
  logic [TASK_COUNT_W-1:0] task_count_r;
  logic                    wr_en;
  logic                    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[CFG_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= POL_EDF;
      task_count_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_POLICY:     policy_r     <= pwdata[0];
        REG_TASK_COUNT: task_count_r <= pwdata[TASK_COUNT_W-1:0];
        default:        policy_r     <= policy_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POLICY:     prdata = CFG_DATA_W'(policy_r);
      REG_TASK_COUNT: prdata = CFG_DATA_W'(task_count_r);
      default:        prdata = '0;
    endcase
  end

  assign policy     = policy_r;
  assign task_count = task_count_r;

endmodule

@@ rtl/rtts_ctrl.sv @@
// Sequencer for the tick scheduler: accepts items, steps scan and countdown walks.
// Depends on rtts_pkg for the command and status bundles.
module rtts_ctrl import rtts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_mode,
  output logic      in_ready,
  input  rtts_sts_t sts,
  output rtts_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_CDN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            cmd.load = 1'b1;
          end else if (in_mode == MODE_TICK) begin
            cmd.tick = 1'b1;
            // skip the scan when the running task is kept
            state_nxt = sts.keep_hit ? ST_CDN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.walk_done) begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_CDN;
        end
      end
      ST_CDN: begin
        cmd.cdn = 1'b1;
        // hold until the output register can take the result
        if (sts.walk_done && !sts.out_full) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rtts_dp.sv @@
// Datapath: task table memories, active bits, table walker, selection and result register.
// Depends on rtts_pkg for commands, status and codes.
module rtts_dp import rtts_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rtts_cmd_t               cmd,
  output rtts_sts_t               sts,
  input  logic                    policy,
  input  logic [TASK_COUNT_W-1:0] task_count,
  input  logic [IN_INDEX_W-1:0]   in_task_index,
  input  logic [IN_TIME_W-1:0]    in_compute_time,
  input  logic [IN_TIME_W-1:0]    in_period,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_idle,
  output logic [OUT_TASK_W-1:0]   out_run_task,
  output logic [JOB_W-1:0]        out_job_number,
  output logic                    out_job_finished
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int TW = TIME_BITS;

  // task table
  logic [TW-1:0]    mem_ce  [MAX_TASKS];
  logic [TW-1:0]    mem_pe  [MAX_TASKS];
  logic [TW-1:0]    mem_cl  [MAX_TASKS];
  logic [TW-1:0]    mem_pl  [MAX_TASKS];
  logic [JOB_W-1:0] mem_job [MAX_TASKS];

  logic [TW-1:0]    rd_ce_r, rd_pe_r, rd_cl_r, rd_pl_r;
  logic [JOB_W-1:0] rd_job_r;

  logic [MAX_TASKS-1:0] active_r;

  logic [CW-1:0] n_w;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rd_vld_r;
  logic [IW-1:0] rd_idx_r;
  logic          walk_rd;

  logic          load_ok;
  logic [IW-1:0] load_idx;
  logic [TW-1:0] ld_c, ld_p;

  logic          best_vld_r;
  logic [IW-1:0] best_idx_r;
  logic [TW-1:0] best_key_r;
  logic [TW-1:0] scan_key;
  logic          scan_take;

  logic          cur_vld_r;
  logic [IW-1:0] cur_r;

  logic             wr_dyn;
  logic             run_hit;
  logic             run_fin;
  logic [TW-1:0]    cl_new, pl_new;
  logic [JOB_W-1:0] job_new;
  logic             act_new;

  logic [JOB_W-1:0] run_job_r;
  logic             run_fin_r;

  logic                  out_valid_r;
  logic                  out_idle_r;
  logic [OUT_TASK_W-1:0] out_run_r;
  logic [JOB_W-1:0]      out_job_r;
  logic                  out_fin_r;

  // entries taking part; counts above the table size act as the table size
  assign n_w = (32'(task_count) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_count);

  assign load_ok  = 32'(in_task_index) < MAX_TASKS;
  assign load_idx = IW'(in_task_index);
  assign ld_c     = TW'(in_compute_time);
  assign ld_p     = TW'(in_period);

  // walker: one read per cycle, data is processed in the cycle after the read
  assign walk_rd = (cmd.scan || cmd.cdn) && (idx_r < n_w);

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.tick || cmd.walk_start) begin
      idx_nxt = '0;
    end else if (walk_rd) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      rd_vld_r <= walk_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_rd) begin
      rd_idx_r <= idx_r[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem_ce[load_idx]  <= ld_c;
      mem_pe[load_idx]  <= ld_p;
      mem_cl[load_idx]  <= ld_c;
      mem_pl[load_idx]  <= ld_p;
      mem_job[load_idx] <= JOB_W'(1);
    end else if (wr_dyn) begin
      mem_cl[rd_idx_r]  <= cl_new;
      mem_pl[rd_idx_r]  <= pl_new;
      mem_job[rd_idx_r] <= job_new;
    end
    rd_ce_r  <= mem_ce[idx_r[IW-1:0]];
    rd_pe_r  <= mem_pe[idx_r[IW-1:0]];
    rd_cl_r  <= mem_cl[idx_r[IW-1:0]];
    rd_pl_r  <= mem_pl[idx_r[IW-1:0]];
    rd_job_r <= mem_job[idx_r[IW-1:0]];
  end

  // selection scan
  assign scan_key  = (policy == POL_RMS) ? rd_pe_r : rd_pl_r;
  assign scan_take = cmd.scan && rd_vld_r && active_r[rd_idx_r] &&
                     (!best_vld_r || (scan_key < best_key_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (cmd.tick) begin
      best_vld_r <= sts.keep_hit;
    end else if (scan_take) begin
      best_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      best_idx_r <= cur_r;
    end else if (scan_take) begin
      best_idx_r <= rd_idx_r;
      best_key_r <= scan_key;
    end
  end

  // run the chosen entry, then count its period down
  assign wr_dyn  = cmd.cdn && rd_vld_r;
  assign run_hit = best_vld_r && (rd_idx_r == best_idx_r);
  assign run_fin = rd_cl_r <= TW'(1);

  always_comb begin
    cl_new  = rd_cl_r;
    job_new = rd_job_r;
    act_new = active_r[rd_idx_r];
    if (run_hit) begin
      if (run_fin) begin
        cl_new  = '0;
        act_new = 1'b0;
        job_new = rd_job_r + JOB_W'(1);
      end else begin
        cl_new = rd_cl_r - TW'(1);
      end
    end
    if (rd_pl_r <= TW'(1)) begin
      pl_new  = rd_pe_r;
      cl_new  = rd_ce_r;
      act_new = 1'b1;
    end else begin
      pl_new = rd_pl_r - TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cmd.load && load_ok) begin
      active_r[load_idx] <= 1'b1;
    end else if (wr_dyn) begin
      active_r[rd_idx_r] <= act_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      run_job_r <= '0;
      run_fin_r <= 1'b0;
    end else if (wr_dyn && run_hit) begin
      run_job_r <= rd_job_r;
      run_fin_r <= run_fin;
    end
  end

  // current task and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      cur_vld_r   <= best_vld_r;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      cur_r      <= best_idx_r;
      out_idle_r <= !best_vld_r;
      out_run_r  <= best_vld_r ? OUT_TASK_W'(best_idx_r) : '0;
      out_job_r  <= run_job_r;
      out_fin_r  <= run_fin_r;
    end
  end

  assign sts.walk_done = (idx_r >= n_w) && !rd_vld_r;
  assign sts.keep_hit  = (policy == POL_RMS) && cur_vld_r &&
                         (CW'(cur_r) < n_w) && active_r[cur_r];
  assign sts.out_full  = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_idle         = out_idle_r;
  assign out_run_task     = out_run_r;
  assign out_job_number   = out_job_r;
  assign out_job_finished = out_fin_r;

endmodule

@@ rtl/realtime_task_tick_scheduler.sv @@
// Periodic task tick scheduler (EDF / RMS) over a table of MAX_TASKS entries.
// Load item: writes one entry, no result. Tick item: the single table read port is swept once to
// select and once to run and count down; the select sweep is skipped when RMS keeps the current
// task. No new item is taken until a tick is through; a result waiting in the output register
// holds the tick behind it.
// Reset (rst_n, synchronous): all tasks inactive, no current task, registers 0.
module realtime_task_tick_scheduler import rtts_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [IN_INDEX_W-1:0] in_task_index,
  input  logic [IN_TIME_W-1:0]  in_compute_time,
  input  logic [IN_TIME_W-1:0]  in_period,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_idle,
  output logic [OUT_TASK_W-1:0] out_run_task,
  output logic [JOB_W-1:0]      out_job_number,
  output logic                  out_job_finished,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                    policy;
  logic [TASK_COUNT_W-1:0] task_count;
  rtts_cmd_t               cmd;
  rtts_sts_t               sts;

  rtts_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .policy     (policy),
    .task_count (task_count)
  );

  rtts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtts_dp #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .policy           (policy),
    .task_count       (task_count),
    .in_task_index    (in_task_index),
    .in_compute_time  (in_compute_time),
    .in_period        (in_period),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_idle         (out_idle),
    .out_run_task     (out_run_task),
    .out_job_number   (out_job_number),
    .out_job_finished (out_job_finished)
  );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for realtime_task_tick_scheduler: predicts each tick's result
// and checks the results in order, under random idling on both channels.
// Depends on rtts_pkg and the scheduler RTL.
module tb;
  import rtts_pkg::*;

  localparam int NUM_ENTRIES   = 8;
  localparam int NO_TASK       = 15;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 113;
  localparam int SETTLE_CYCLES = 2 * NUM_ENTRIES + 3 + 10;

  typedef struct packed {
    logic                  idle;
    logic [OUT_TASK_W-1:0] run_task;
    logic [JOB_W-1:0]      job_number;
    logic                  job_finished;
  } tick_result_t;

  class tick_board;
    logic                 policy;
    int unsigned          task_count;
    logic [IN_TIME_W-1:0] compute_each [NUM_ENTRIES];
    logic [IN_TIME_W-1:0] period_each  [NUM_ENTRIES];
    logic [IN_TIME_W-1:0] compute_left [NUM_ENTRIES];
    logic [IN_TIME_W-1:0] period_left  [NUM_ENTRIES];
    bit                   active       [NUM_ENTRIES];
    logic [JOB_W-1:0]     job_count    [NUM_ENTRIES];
    int                   current_task;
    tick_result_t         expected_ticks [$];
    int unsigned          errors;
    int unsigned          checked;

    function new();
      policy = POL_EDF;
      task_count = 0;
      current_task = NO_TASK;
      errors = 0;
      checked = 0;
      for (int j = 0; j < NUM_ENTRIES; j++) begin
        compute_each[j] = '0;
        period_each[j] = '0;
        compute_left[j] = '0;
        period_left[j] = '0;
        active[j] = 1'b0;
        job_count[j] = '0;
      end
    endfunction

    // Advance the table by one accepted input transfer; ticks queue their result.
    function void note_transfer(logic mode, logic [IN_INDEX_W-1:0] idx,
                                logic [IN_TIME_W-1:0] c, logic [IN_TIME_W-1:0] p);
      int n;
      int sel;
      logic [IN_TIME_W-1:0] key;
      logic [IN_TIME_W-1:0] best_key;
      tick_result_t res;
      if (mode == MODE_LOAD) begin
        compute_each[idx] = c;
        period_each[idx] = p;
        compute_left[idx] = c;
        period_left[idx] = p;
        active[idx] = 1'b1;
        job_count[idx] = JOB_W'(1);
        return;
      end
      n = (task_count > NUM_ENTRIES) ? NUM_ENTRIES : task_count;
      sel = NO_TASK;
      best_key = '0;
      // RMS keeps the running task while it is still in range and active
      if (policy == POL_RMS && current_task < n && active[current_task]) begin
        sel = current_task;
      end else begin
        for (int j = 0; j < n; j++) begin
          if (!active[j]) continue;
          key = (policy == POL_EDF) ? period_left[j] : period_each[j];
          if (sel == NO_TASK || key < best_key) begin
            sel = j;
            best_key = key;
          end
        end
      end
      current_task = sel;
      res = '0;
      res.idle = 1'b1;
      if (sel != NO_TASK) begin
        res.idle = 1'b0;
        res.run_task = sel[OUT_TASK_W-1:0];
        res.job_number = job_count[sel];
        if (compute_left[sel] <= 1) begin
          compute_left[sel] = '0;
          active[sel] = 1'b0;
          job_count[sel] = job_count[sel] + 1'b1;
          res.job_finished = 1'b1;
        end else begin
          compute_left[sel] = compute_left[sel] - 1'b1;
        end
      end
      // a period counter at zero behaves like one and reloads
      for (int j = 0; j < n; j++) begin
        if (period_left[j] <= 1) begin
          period_left[j] = period_each[j];
          compute_left[j] = compute_each[j];
          active[j] = 1'b1;
        end else begin
          period_left[j] = period_left[j] - 1'b1;
        end
      end
      expected_ticks.push_back(res);
    endfunction

    function void check_tick(tick_result_t got);
      tick_result_t want;
      if (expected_ticks.size() == 0) begin
        $error("unexpected tick result: idle %0d run_task %0d", got.idle, got.run_task);
        errors++;
        return;
      end
      want = expected_ticks.pop_front();
      checked++;
      if (got.idle !== want.idle) begin
        $error("idle: expected %0d, got %0d", want.idle, got.idle);
        errors++;
      end
      if (got.run_task !== want.run_task) begin
        $error("run_task: expected %0d, got %0d", want.run_task, got.run_task);
        errors++;
      end
      if (got.job_number !== want.job_number) begin
        $error("job_number: expected %0d, got %0d", want.job_number, got.job_number);
        errors++;
      end
      if (got.job_finished !== want.job_finished) begin
        $error("job_finished: expected %0d, got %0d", want.job_finished, got.job_finished);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [IN_INDEX_W-1:0] in_task_index;
  logic [IN_TIME_W-1:0]  in_compute_time;
  logic [IN_TIME_W-1:0]  in_period;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_idle;
  logic [OUT_TASK_W-1:0] out_run_task;
  logic [JOB_W-1:0]      out_job_number;
  logic                  out_job_finished;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  tick_board board;
  bit        burst;

  realtime_task_tick_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_task_index(in_task_index), .in_compute_time(in_compute_time),
    .in_period(in_period),
    .out_valid(out_valid), .out_ready(out_ready), .out_idle(out_idle),
    .out_run_task(out_run_task), .out_job_number(out_job_number),
    .out_job_finished(out_job_finished),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin : monitor
    tick_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.idle = out_idle;
      got.run_task = out_run_task;
      got.job_number = out_job_number;
      got.job_finished = out_job_finished;
      board.check_tick(got);
    end
    if (rst_n && in_valid && in_ready)
      board.note_transfer(in_mode, in_task_index, in_compute_time, in_period);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called right after a rising edge; returns once the transfer has happened.
  task automatic send_item(logic mode, logic [IN_INDEX_W-1:0] idx,
                           logic [IN_TIME_W-1:0] c, logic [IN_TIME_W-1:0] p);
    int gap;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_task_index <= idx;
    in_compute_time <= c;
    in_period <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic                  mode;
    logic [IN_INDEX_W-1:0] idx;
    logic [IN_TIME_W-1:0]  c;
    logic [IN_TIME_W-1:0]  p;
    mode = ($urandom_range(0, 99) < 15) ? MODE_LOAD : MODE_TICK;
    idx = IN_INDEX_W'($urandom_range(0, NUM_ENTRIES - 1));
    // short periods keep jobs finishing and reloading; a few take the full range
    if ($urandom_range(0, 9) == 0) begin
      c = IN_TIME_W'($urandom_range(0, 4095));
      p = IN_TIME_W'($urandom_range(0, 4095));
    end else begin
      p = IN_TIME_W'($urandom_range(1, 24));
      c = IN_TIME_W'($urandom_range(0, p));
    end
    send_item(mode, idx, c, p);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every pending tick result, then let a load still in flight settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic pol, logic [TASK_COUNT_W-1:0] cnt);
    drain();
    cfg_write({REG_POLICY, 2'b00}, {{(CFG_DATA_W-1){1'b0}}, pol});
    cfg_write({REG_TASK_COUNT, 2'b00}, {{(CFG_DATA_W-TASK_COUNT_W){1'b0}}, cnt});
    board.policy = pol;
    board.task_count = 32'(cnt);
  endtask

  initial begin : stimulus
    logic                    pol;
    logic [TASK_COUNT_W-1:0] cnt;
    int                      pick;
    board = new();
    burst = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= MODE_TICK;
    in_task_index <= '0;
    in_compute_time <= '0;
    in_period <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no entries take part yet: idle tick
    send_item(MODE_TICK, 3'd0, 12'd0, 12'd0);
    send_item(MODE_LOAD, 3'd0, 12'd2, 12'd5);
    send_item(MODE_LOAD, 3'd1, 12'd4095, 12'd4095);
    send_item(MODE_LOAD, 3'd2, 12'd1, 12'd1);
    send_item(MODE_LOAD, 3'd3, 12'd0, 12'd6);
    send_item(MODE_LOAD, 3'd4, 12'd3, 12'd8);
    send_item(MODE_LOAD, 3'd5, 12'd2, 12'd4);
    send_item(MODE_LOAD, 3'd6, 12'd1, 12'd3);
    send_item(MODE_LOAD, 3'd7, 12'd0, 12'd0);
    // entry 7 (zero period) stays outside the count first
    set_mode(POL_EDF, 4'd7);
    repeat (6) send_item(MODE_TICK, 3'd7, 12'hfff, 12'hfff);
    // count above the table size acts as the full table
    set_mode(POL_RMS, 4'd15);
    repeat (4) send_item(MODE_TICK, 3'd0, 12'd0, 12'd0);
    // shrink the count under the kept task
    set_mode(POL_RMS, 4'd1);
    repeat (2) send_item(MODE_TICK, 3'd0, 12'd0, 12'd0);
    send_item(MODE_LOAD, 3'd0, 12'd4095, 12'd1);
    send_item(MODE_TICK, 3'd0, 12'd0, 12'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      pol = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick == 0) cnt = 4'd0;
      else if (pick == 1) cnt = TASK_COUNT_W'($urandom_range(9, 15));
      else cnt = TASK_COUNT_W'($urandom_range(1, NUM_ENTRIES));
      if (ph == 0) begin
        pol = POL_EDF;
        cnt = TASK_COUNT_W'(NUM_ENTRIES);
      end
      if (ph == 1) begin
        pol = POL_RMS;
        cnt = TASK_COUNT_W'(NUM_ENTRIES);
      end
      set_mode(pol, cnt);
      burst = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_random();
    end

    drain();
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int stall;
    int run;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      // one long hold-off so the block fills up and stalls its input
      if (!held && board.checked >= 300) begin
        stall = 400;
        held = 1'b1;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  initial begin : watchdog
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
